// ===== hdl/aes_pkg.sv =====
package aes_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEXP,
        ST_INIT,
        ST_ROUND,
        ST_OUT,
        ST_PAD
    } state_t;

    localparam logic [2:0] CFG_KEY_0   = 3'd0;
    localparam logic [2:0] CFG_KEY_1   = 3'd1;
    localparam logic [2:0] CFG_KEY_2   = 3'd2;
    localparam logic [2:0] CFG_KEY_3   = 3'd3;
    localparam logic [2:0] CFG_IV_HIGH = 3'd4;
    localparam logic [2:0] CFG_IV_LOW  = 3'd5;
    localparam logic [2:0] CFG_DECRYPT = 3'd6;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    // GF(2^8) multiply, reduction polynomial 0x11b
    function automatic logic [7:0] gm(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        r = '0;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = r ^ x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        end
        return r;
    endfunction

    // inverse S-box as a constant table
    function automatic logic [7:0] inv_sbox(input logic [7:0] y);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[y];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0: r = 8'h01;
            3'd1: r = 8'h02;
            3'd2: r = 8'h04;
            3'd3: r = 8'h08;
            3'd4: r = 8'h10;
            3'd5: r = 8'h20;
            default: r = 8'h40;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/aes_if.sv =====
interface aes_in_if;
    logic         valid;
    logic         ready;
    logic [63:0]  data_high;
    logic [63:0]  data_low;
    logic [4:0]   valid_bytes;
    logic         last_block;
    modport source (output valid, data_high, data_low, valid_bytes, last_block, input ready);
    modport sink   (input valid, data_high, data_low, valid_bytes, last_block, output ready);
endinterface

interface aes_out_if;
    logic         valid;
    logic         ready;
    logic [63:0]  out_high;
    logic [63:0]  out_low;
    logic [4:0]   out_bytes;
    logic         pad_error;
    logic         out_last;
    modport source (output valid, out_high, out_low, out_bytes, pad_error, out_last, input ready);
    modport sink   (input valid, out_high, out_low, out_bytes, pad_error, out_last, output ready);
endinterface

interface aes_cfg_if;
    logic         valid;
    logic         ready;
    logic [2:0]   index;
    logic [63:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/aes_round.sv =====
module aes_round (
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    input  logic         decrypt,
    input  logic         first,
    input  logic         final_round,
    output logic [127:0] state_out
);
    import aes_pkg::*;

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] k [16];
    logic [7:0] a0, a1, a2, a3;

    always_comb
    begin
        for (int i = 0; i < 16; i++) begin
            s[i] = state_in[127-8*i -: 8];
            k[i] = round_key[127-8*i -: 8];
        end
        // substitution and row shift
        for (int c = 0; c < 4; c++) begin
            for (int w = 0; w < 4; w++) begin
                if (decrypt)
                    t[4*((c+w)&3)+w] = inv_sbox(s[4*c+w]);
                else
                    t[4*c+w] = sbox(s[4*((c+w)&3)+w]);
            end
        end
        // encrypt: mix then key; decrypt: key then inverse mix
        for (int i = 0; i < 16; i++) begin
            if (first)
                m[i] = s[i] ^ k[i];
            else if (decrypt)
                m[i] = t[i] ^ k[i];
            else
                m[i] = t[i];
        end
        for (int c = 0; c < 4; c++) begin
            a0 = m[4*c]; a1 = m[4*c+1]; a2 = m[4*c+2]; a3 = m[4*c+3];
            if (!first && !final_round) begin
                if (decrypt) begin
                    m[4*c]   = gm(a0,8'h0e)^gm(a1,8'h0b)^gm(a2,8'h0d)^gm(a3,8'h09);
                    m[4*c+1] = gm(a0,8'h09)^gm(a1,8'h0e)^gm(a2,8'h0b)^gm(a3,8'h0d);
                    m[4*c+2] = gm(a0,8'h0d)^gm(a1,8'h09)^gm(a2,8'h0e)^gm(a3,8'h0b);
                    m[4*c+3] = gm(a0,8'h0b)^gm(a1,8'h0d)^gm(a2,8'h09)^gm(a3,8'h0e);
                end else begin
                    m[4*c]   = xt(a0)^xt(a1)^a1^a2^a3;
                    m[4*c+1] = a0^xt(a1)^xt(a2)^a2^a3;
                    m[4*c+2] = a0^a1^xt(a2)^xt(a3)^a3;
                    m[4*c+3] = xt(a0)^a0^a1^a2^xt(a3);
                end
            end
        end
        for (int i = 0; i < 16; i++) begin
            if (!first && !decrypt)
                state_out[127-8*i -: 8] = m[i] ^ k[i];
            else
                state_out[127-8*i -: 8] = m[i];
        end
    end
endmodule

// ===== hdl/aes_keyexp.sv =====
module aes_keyexp (
    input  logic [127:0] prev2,
    input  logic [127:0] prev1,
    input  logic [2:0]   rc_idx,
    input  logic         odd,
    output logic [127:0] next_key
);
    import aes_pkg::*;

    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    logic [31:0] l;

    // one 128-bit half step of the 256-bit schedule
    always_comb
    begin
        l = prev1[31:0];
        if (!odd)
            t = {sbox(l[23:16]) ^ rcon(rc_idx), sbox(l[15:8]), sbox(l[7:0]), sbox(l[31:24])};
        else
            t = {sbox(l[31:24]), sbox(l[23:16]), sbox(l[15:8]), sbox(l[7:0])};
        w0 = prev2[127:96] ^ t;
        w1 = prev2[95:64] ^ w0;
        w2 = prev2[63:32] ^ w1;
        w3 = prev2[31:0] ^ w2;
        next_key = {w0, w1, w2, w3};
    end
endmodule

// ===== hdl/aes256_cbc_pkcs7_engine.sv =====
// Channel  | Dir | Contents
// in_ch    | in  | data_high, data_low, valid_bytes, last_block
// out_ch   | out | out_high, out_low, out_bytes, pad_error, out_last
// cfg_ch   | in  | index (0..6), data
// One block: an initial key add in INIT, the rounds in ROUND and an output
// load in OUT. A new block is accepted only in IDLE, after the previous one
// has left OUT. A message start first builds the round keys in KEXP. A full
// last block when encrypting runs a second pass through PAD and INIT.
// A finished block waits in OUT until the previous result transfers out.
// rst_n is asynchronous and clears control state, configuration and chain_reg.
module aes256_cbc_pkcs7_engine (
    input  logic clk,
    input  logic rst_n,
    aes_in_if.sink    in_ch,
    aes_out_if.source out_ch,
    aes_cfg_if.sink   cfg_ch
);
    import aes_pkg::*;

    state_t state_reg, state_next;
    logic [127:0] key_reg [2];
    logic [127:0] iv_reg;
    logic         dec_reg;
    logic [127:0] rk_mem [15];
    logic [127:0] rk_rd;
    logic [3:0]   rnd_reg;
    logic [127:0] st_reg, chain_reg, din_reg;
    logic         start_reg, last_reg, blk_dec_reg, pad2_reg;
    logic [127:0] rnd_out, kx_out, blk_in;
    logic [127:0] in_blk;
    logic [3:0]   rk_idx;
    logic [127:0] kx_prev2, kx_prev1;
    logic [127:0] res;
    logic [7:0]   p;
    logic         perr;
    logic         ovalid_reg;
    logic [127:0] ores_reg;
    logic [4:0]   obytes_reg;
    logic         oerr_reg, olast_reg;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign in_blk       = {in_ch.data_high, in_ch.data_low};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_reg[0] <= '0;
            key_reg[1] <= '0;
            iv_reg     <= '0;
            dec_reg    <= 1'b0;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.index)
                CFG_KEY_0:   key_reg[0][127:64] <= cfg_ch.data;
                CFG_KEY_1:   key_reg[0][63:0]   <= cfg_ch.data;
                CFG_KEY_2:   key_reg[1][127:64] <= cfg_ch.data;
                CFG_KEY_3:   key_reg[1][63:0]   <= cfg_ch.data;
                CFG_IV_HIGH: iv_reg[127:64] <= cfg_ch.data;
                CFG_IV_LOW:  iv_reg[63:0]   <= cfg_ch.data;
                CFG_DECRYPT: dec_reg        <= cfg_ch.data[0];
                default: ;
            endcase
        end
    end

    // key schedule: rnd_reg counts round key 2..14 being built
    assign kx_prev2 = rk_mem[(rnd_reg < 4'd2) ? 4'd0 : rnd_reg - 4'd2];
    assign kx_prev1 = rk_mem[(rnd_reg == 4'd0) ? 4'd0 : rnd_reg - 4'd1];
    aes_keyexp u_kx (
        .prev2(kx_prev2), .prev1(kx_prev1),
        .rc_idx(3'((rnd_reg >> 1) - 4'd1)), .odd(rnd_reg[0]), .next_key(kx_out)
    );

    // round key memory, registered read; rnd_reg holds the current round
    always_comb
    begin
        rk_idx = 4'd0;
        if (state_reg == ST_INIT)
            rk_idx = blk_dec_reg ? 4'd13 : 4'd1;
        else if (state_reg == ST_ROUND) begin
            if (blk_dec_reg)
                rk_idx = (rnd_reg == 4'd0) ? 4'd0 : 4'(rnd_reg - 4'd1);
            else
                rk_idx = (rnd_reg == 4'd14) ? 4'd0 : 4'(rnd_reg + 4'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_KEXP)
            rk_mem[rnd_reg] <= kx_out;
        else if (in_ch.valid && in_ch.ready && start_reg) begin
            rk_mem[0] <= key_reg[0];
            rk_mem[1] <= key_reg[1];
        end
        rk_rd <= rk_mem[rk_idx];
    end

    assign blk_in = blk_dec_reg ? din_reg : (din_reg ^ chain_reg);

    aes_round u_rnd (
        .state_in(state_reg == ST_INIT ? blk_in : st_reg),
        .round_key(state_reg == ST_INIT ? (blk_dec_reg ? rk_mem[14] : rk_mem[0]) : rk_rd),
        .decrypt(blk_dec_reg),
        .first(state_reg == ST_INIT),
        .final_round(blk_dec_reg ? (rnd_reg == 4'd0) : (rnd_reg == 4'd14)),
        .state_out(rnd_out)
    );

    // padding check on the decrypted block
    assign res = blk_dec_reg ? (st_reg ^ chain_reg) : st_reg;
    always_comb
    begin
        p = res[7:0];
        perr = (p == 8'd0) || (p > 8'd16);
        for (int i = 0; i < 16; i++) begin
            if ((5'(i) >= 5'd16 - p[4:0]) && (res[127-8*i -: 8] != p) && !perr)
                perr = 1'b1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_ch.valid) state_next = start_reg ? ST_KEXP : ST_INIT;
            ST_KEXP: if (rnd_reg == 4'd14) state_next = ST_INIT;
            ST_INIT: state_next = ST_ROUND;
            ST_ROUND:
                if (blk_dec_reg ? (rnd_reg == 4'd0) : (rnd_reg == 4'd14))
                    state_next = ST_OUT;
            ST_OUT: if (!ovalid_reg) state_next = pad2_reg ? ST_PAD : ST_IDLE;
            ST_PAD: state_next = ST_INIT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            start_reg  <= 1'b1;
            ovalid_reg <= 1'b0;
            rnd_reg    <= '0;
            chain_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (out_ch.ready && ovalid_reg) ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (in_ch.valid) begin
                        start_reg <= in_ch.last_block;
                        rnd_reg   <= 4'd2;
                        if (start_reg) chain_reg <= iv_reg;
                    end
                ST_KEXP: rnd_reg <= rnd_reg + 4'd1;
                ST_INIT:
                    begin
                        rnd_reg <= blk_dec_reg ? 4'd13 : 4'd1;
                        if (blk_dec_reg) chain_reg <= chain_reg;
                    end
                ST_ROUND: rnd_reg <= blk_dec_reg ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
                ST_OUT:
                    if (!ovalid_reg) begin
                        ovalid_reg <= 1'b1;
                        chain_reg  <= blk_dec_reg ? din_reg : st_reg;
                    end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_ch.valid) begin
            blk_dec_reg <= dec_reg;
            last_reg    <= in_ch.last_block;
            pad2_reg    <= !dec_reg && in_ch.last_block && (in_ch.valid_bytes >= 5'd16);
            for (int i = 0; i < 16; i++) begin
                if (!dec_reg && in_ch.last_block && 5'(i) >= in_ch.valid_bytes)
                    din_reg[127-8*i -: 8] <= 8'(5'd16 - in_ch.valid_bytes);
                else
                    din_reg[127-8*i -: 8] <= in_blk[127-8*i -: 8];
            end
        end else if (state_reg == ST_PAD) begin
            din_reg  <= {16{8'h10}};
            pad2_reg <= 1'b0;
        end
        if (state_reg == ST_INIT || state_reg == ST_ROUND)
            st_reg <= rnd_out;
        if (state_reg == ST_OUT && !ovalid_reg) begin
            ores_reg <= res;
            if (blk_dec_reg) begin
                oerr_reg   <= last_reg && perr;
                obytes_reg <= !last_reg ? 5'd16 : (perr ? 5'd0 : 5'(5'd16 - p[4:0]));
            end else begin
                oerr_reg   <= 1'b0;
                obytes_reg <= 5'd16;
            end
            olast_reg <= last_reg && !pad2_reg;
        end
    end

    assign out_ch.valid     = ovalid_reg;
    assign out_ch.out_high  = ores_reg[127:64];
    assign out_ch.out_low   = ores_reg[63:0];
    assign out_ch.out_bytes = obytes_reg;
    assign out_ch.pad_error = oerr_reg;
    assign out_ch.out_last  = olast_reg;
endmodule

// ===== hdl/aes_checker.sv =====
module aes_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [4:0] out_bytes,
    input logic pad_error
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("output dropped");
    a_err_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pad_error |-> out_bytes == 5'd0) else $error("bad error bytes");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("accepted while busy");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_bytes <= 5'd16) else $error("bytes out of range");
endmodule

bind aes256_cbc_pkcs7_engine aes_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_bytes(out_ch.out_bytes), .pad_error(out_ch.pad_error)
);
